>>> rtl/ufl_pkg.sv
// Shared types and constants for the unicycle feedback linearization unit.
// No dependencies; used by the top level, its checker and the testbench.
package ufl_pkg;

    localparam int POS_WIDTH_DEFAULT    = 16;
    localparam int ANGLE_STAGES_DEFAULT = 16;

    localparam int GUARD_BITS  = 12;
    localparam int ANGLE_W     = 32;
    localparam int KINV_FRAC   = 30;
    localparam int GAIN_FRAC   = 12;
    localparam int U_W         = 18;
    localparam int W_W         = 24;
    localparam int OUT_DATA_W  = ((U_W + W_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int RSQ_W       = 2 * CFG_DATA_W;

    localparam logic [CFG_DATA_W-1:0] ARRIVAL_RADIUS_RESET = 16'd26;
    localparam logic [CFG_DATA_W-1:0] TURN_GAIN_RESET      = 16'd4096;
    localparam logic [RSQ_W-1:0]      RADIUS_SQ_RESET      =
        RSQ_W'(ARRIVAL_RADIUS_RESET) * RSQ_W'(ARRIVAL_RADIUS_RESET);

    // 1/K of the rotator, Q0.30
    localparam logic [KINV_FRAC-1:0]     INV_GAIN_Q30 = 30'd652032874;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q28 = 32'sd421657428;

    localparam int ATAN_LEN = 24;
    localparam logic signed [ANGLE_W-1:0] ATAN_Q28 [ATAN_LEN] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755421,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ARRIVAL_RADIUS,
        CFG_TURN_GAIN
    } cfg_reg_t;

endpackage

>>> rtl/unicycle_feedback_linearization_unit.sv
// Unicycle feedback linearization: pipelined CORDIC rotator, 1/K scaling,
// turn gain and arrival test. Depends on ufl_pkg.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | target_x, target_y, current_x, current_y, heading
//  m_      | out | m_tvalid/m_tready | linear_drive, turn_rate; arrived on m_tuser
//  cfg_    | in  | cfg_valid/ready   | cfg_index, cfg_data (always ready)
//
// One beat per cycle unless the output stalls; the pipeline has one register
// per rotator stage plus difference, pre-rotation, two multiply stages,
// gain multiply and the output register.
// Reset clears all valid bits and loads radius 26 (0.1) and gain 4096 (1.0).
// A stalled output freezes the whole pipeline; s_tready = !m_tvalid || m_tready.
module unicycle_feedback_linearization_unit #(
    parameter int  POS_WIDTH    = ufl_pkg::POS_WIDTH_DEFAULT,
    parameter int  ANGLE_STAGES = ufl_pkg::ANGLE_STAGES_DEFAULT,
    localparam int IN_W         = ((4 * POS_WIDTH + 16 + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // target_x, target_y, current_x, current_y, heading (from bit 0 up)
    input  logic [IN_W-1:0]                   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // linear_drive, turn_rate (from bit 0 up), zero padded
    output logic [ufl_pkg::OUT_DATA_W-1:0]    m_tdata,
    // arrived
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ufl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ufl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DW       = POS_WIDTH + 1;
    localparam int XW       = POS_WIDTH + 16;
    localparam int ZW       = ufl_pkg::ANGLE_W;
    localparam int SQW_FULL = 2 * POS_WIDTH + 3;
    localparam int SQW      = (SQW_FULL > 64) ? 64 : SQW_FULL;
    localparam int CMPW     = (SQW > ufl_pkg::RSQ_W) ? SQW : ufl_pkg::RSQ_W;
    localparam int LO_W     = 16;
    localparam int HI_W     = XW - LO_W;
    localparam int KW       = ufl_pkg::KINV_FRAC + 1;
    localparam int PW       = XW + KW;
    localparam int RND      = ufl_pkg::KINV_FRAC + ufl_pkg::GUARD_BITS;
    localparam int RW       = PW - RND;
    localparam int UEW      = (RW > ufl_pkg::U_W) ? RW : ufl_pkg::U_W;
    localparam int GP_W     = RW + ufl_pkg::CFG_DATA_W + 1;
    localparam int WRW      = GP_W - ufl_pkg::GAIN_FRAC;
    localparam int WEW      = (WRW > ufl_pkg::W_W) ? WRW : ufl_pkg::W_W;
    localparam int LAST     = ANGLE_STAGES - 1;
    localparam int PAD_W    = ufl_pkg::OUT_DATA_W - ufl_pkg::U_W - ufl_pkg::W_W;

    localparam logic signed [KW-1:0]  KINV_S   = KW'(ufl_pkg::INV_GAIN_Q30);
    localparam logic signed [ZW-1:0]  NEG_HALF = -ufl_pkg::HALF_PI_Q28;
    localparam logic signed [UEW-1:0] U_MAX    = UEW'(2 ** (ufl_pkg::U_W - 1) - 1);
    localparam logic signed [UEW-1:0] U_MIN    = UEW'(-(2 ** (ufl_pkg::U_W - 1)));
    localparam logic signed [WEW-1:0] W_MAX    = WEW'(2 ** (ufl_pkg::W_W - 1) - 1);
    localparam logic signed [WEW-1:0] W_MIN    = WEW'(-(2 ** (ufl_pkg::W_W - 1)));

    // configuration
    logic [ufl_pkg::RSQ_W-1:0]      rsq_reg;
    logic [ufl_pkg::CFG_DATA_W-1:0] gain_reg;

    // pipeline advance
    logic adv;

    // stage 1: differences and negated heading
    logic                 v1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg;
    logic signed [ZW-1:0] z1_reg;
    logic signed [DW-1:0] dx1_next, dy1_next;
    logic signed [ZW-1:0] z1_next;

    // stage 2: quarter-turn pre-rotation and squares
    logic                     v2_reg;
    logic signed [XW-1:0]     x2_reg, y2_reg;
    logic signed [ZW-1:0]     z2_reg;
    logic signed [2*DW-1:0]   sqx2_reg, sqy2_reg;
    logic signed [XW-1:0]     x2_next, y2_next, xt;
    logic signed [ZW-1:0]     z2_next;
    logic signed [2*DW-1:0]   sqx2_next, sqy2_next;
    logic [SQW_FULL-1:0]      sq_sum;
    logic                     arr_cmp;

    // rotator stages
    logic                 cv_reg [ANGLE_STAGES];
    logic                 ca_reg [ANGLE_STAGES];
    logic signed [XW-1:0] cx_reg [ANGLE_STAGES];
    logic signed [XW-1:0] cy_reg [ANGLE_STAGES];
    logic signed [ZW-1:0] cz_reg [ANGLE_STAGES];
    logic                 cv_in  [ANGLE_STAGES];
    logic                 ca_in  [ANGLE_STAGES];
    logic signed [XW-1:0] cx_in  [ANGLE_STAGES];
    logic signed [XW-1:0] cy_in  [ANGLE_STAGES];
    logic signed [ZW-1:0] cz_in  [ANGLE_STAGES];
    logic signed [XW-1:0] cx_next [ANGLE_STAGES];
    logic signed [XW-1:0] cy_next [ANGLE_STAGES];
    logic signed [ZW-1:0] cz_next [ANGLE_STAGES];

    // 1/K multiply, split in high and low partial products
    logic                              mv_reg, ma_reg;
    logic signed [HI_W+KW-1:0]         uh_reg, vh_reg;
    logic [LO_W+ufl_pkg::KINV_FRAC-1:0] ul_reg, vl_reg;
    logic signed [HI_W+KW-1:0]         uh_next, vh_next;
    logic [LO_W+ufl_pkg::KINV_FRAC-1:0] ul_next, vl_next;

    // rounding of u and v, saturation of u
    logic                         rv_reg, ra_reg;
    logic signed [ufl_pkg::U_W-1:0] ru_reg;
    logic signed [RW-1:0]         rvv_reg;
    logic signed [PW-1:0]         ufull, vfull;
    logic signed [RW-1:0]         ur_raw;
    logic signed [UEW-1:0]        ue;
    logic signed [ufl_pkg::U_W-1:0] ru_next;

    // gain multiply
    logic                           wv_reg, wa_reg;
    logic signed [ufl_pkg::U_W-1:0] wu_reg;
    logic signed [GP_W-1:0]         gp_reg;
    logic signed [GP_W-1:0]         gp_next;

    // output register
    logic                           m_tvalid_reg, out_a_reg;
    logic signed [ufl_pkg::U_W-1:0] out_u_reg;
    logic signed [ufl_pkg::W_W-1:0] out_w_reg;
    logic signed [GP_W-1:0]         wfull;
    logic signed [WEW-1:0]          we;
    logic signed [ufl_pkg::W_W-1:0] out_w_next;

    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = out_a_reg;
    assign m_tdata   = {{PAD_W{1'b0}}, out_w_reg, out_u_reg};

    // configuration; radius is kept squared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsq_reg  <= ufl_pkg::RADIUS_SQ_RESET;
            gain_reg <= ufl_pkg::TURN_GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (ufl_pkg::cfg_reg_t'(cfg_index))
                ufl_pkg::CFG_ARRIVAL_RADIUS:
                    rsq_reg <= ufl_pkg::RSQ_W'(cfg_data) * ufl_pkg::RSQ_W'(cfg_data);
                ufl_pkg::CFG_TURN_GAIN:
                    gain_reg <= cfg_data;
                default:
                    gain_reg <= gain_reg;
            endcase
        end
    end

    // stage 1
    always_comb
    begin
        dx1_next = $signed({s_tdata[POS_WIDTH-1], s_tdata[POS_WIDTH-1:0]})
                 - $signed({s_tdata[3*POS_WIDTH-1], s_tdata[3*POS_WIDTH-1:2*POS_WIDTH]});
        dy1_next = $signed({s_tdata[2*POS_WIDTH-1], s_tdata[2*POS_WIDTH-1:POS_WIDTH]})
                 - $signed({s_tdata[4*POS_WIDTH-1], s_tdata[4*POS_WIDTH-1:3*POS_WIDTH]});
        // heading Q3.13 to 2^-28 rad, negated
        z1_next  = -($signed({{(ZW-16){s_tdata[4*POS_WIDTH+15]}},
                              s_tdata[4*POS_WIDTH+15:4*POS_WIDTH]}) <<< 15);
    end

    // stage 2: at most two quarter turns bring z into [-pi/2, pi/2]
    always_comb
    begin
        x2_next = XW'(dx1_reg) <<< ufl_pkg::GUARD_BITS;
        y2_next = XW'(dy1_reg) <<< ufl_pkg::GUARD_BITS;
        z2_next = z1_reg;
        xt      = x2_next;
        for (int k = 0; k < 2; k++)
        begin
            xt = x2_next;
            priority if (z2_next > ufl_pkg::HALF_PI_Q28)
            begin
                x2_next = -y2_next;
                y2_next = xt;
                z2_next = z2_next - ufl_pkg::HALF_PI_Q28;
            end
            else if (z2_next < NEG_HALF)
            begin
                x2_next = y2_next;
                y2_next = -xt;
                z2_next = z2_next + ufl_pkg::HALF_PI_Q28;
            end
            else
            begin
                z2_next = z2_next;
            end
        end
        sqx2_next = dx1_reg * dx1_reg;
        sqy2_next = dy1_reg * dy1_reg;
    end

    // arrival test, wraps at 64 bits for the widest positions
    always_comb
    begin
        sq_sum  = SQW_FULL'($unsigned(sqx2_reg)) + SQW_FULL'($unsigned(sqy2_reg));
        arr_cmp = CMPW'(sq_sum[SQW-1:0]) < CMPW'(rsq_reg);
    end

    // rotator: stage i shifts by i, direction from the sign of z
    always_comb
    begin
        cv_in[0] = v2_reg;
        ca_in[0] = arr_cmp;
        cx_in[0] = x2_reg;
        cy_in[0] = y2_reg;
        cz_in[0] = z2_reg;
        for (int i = 1; i < ANGLE_STAGES; i++)
        begin
            cv_in[i] = cv_reg[i-1];
            ca_in[i] = ca_reg[i-1];
            cx_in[i] = cx_reg[i-1];
            cy_in[i] = cy_reg[i-1];
            cz_in[i] = cz_reg[i-1];
        end
        for (int i = 0; i < ANGLE_STAGES; i++)
        begin
            if (!cz_in[i][ZW-1])
            begin
                cx_next[i] = cx_in[i] - (cy_in[i] >>> i);
                cy_next[i] = cy_in[i] + (cx_in[i] >>> i);
                cz_next[i] = cz_in[i] - ufl_pkg::ATAN_Q28[i];
            end
            else
            begin
                cx_next[i] = cx_in[i] + (cy_in[i] >>> i);
                cy_next[i] = cy_in[i] - (cx_in[i] >>> i);
                cz_next[i] = cz_in[i] + ufl_pkg::ATAN_Q28[i];
            end
        end
    end

    // 1/K partial products
    always_comb
    begin
        uh_next = $signed(cx_reg[LAST][XW-1:LO_W]) * KINV_S;
        vh_next = $signed(cy_reg[LAST][XW-1:LO_W]) * KINV_S;
        ul_next = (LO_W+ufl_pkg::KINV_FRAC)'(cx_reg[LAST][LO_W-1:0])
                * (LO_W+ufl_pkg::KINV_FRAC)'(ufl_pkg::INV_GAIN_Q30);
        vl_next = (LO_W+ufl_pkg::KINV_FRAC)'(cy_reg[LAST][LO_W-1:0])
                * (LO_W+ufl_pkg::KINV_FRAC)'(ufl_pkg::INV_GAIN_Q30);
    end

    // recombine, round half up, saturate u
    always_comb
    begin
        ufull  = (PW'(uh_reg) <<< LO_W) + $signed(PW'(ul_reg))
               + $signed(PW'(64'd1 << (RND - 1)));
        vfull  = (PW'(vh_reg) <<< LO_W) + $signed(PW'(vl_reg))
               + $signed(PW'(64'd1 << (RND - 1)));
        ur_raw = ufull[PW-1:RND];
        ue     = UEW'(ur_raw);
        priority if (ue > U_MAX)
            ru_next = ufl_pkg::U_W'(U_MAX);
        else if (ue < U_MIN)
            ru_next = ufl_pkg::U_W'(U_MIN);
        else
            ru_next = ufl_pkg::U_W'(ue);
    end

    assign gp_next = rvv_reg * $signed({1'b0, gain_reg});

    // round gain product by 12 bits, saturate w
    always_comb
    begin
        wfull = gp_reg + $signed(GP_W'(64'd1 << (ufl_pkg::GAIN_FRAC - 1)));
        we    = WEW'($signed(wfull[GP_W-1:ufl_pkg::GAIN_FRAC]));
        priority if (we > W_MAX)
            out_w_next = ufl_pkg::W_W'(W_MAX);
        else if (we < W_MIN)
            out_w_next = ufl_pkg::W_W'(W_MIN);
        else
            out_w_next = ufl_pkg::W_W'(we);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            mv_reg       <= 1'b0;
            rv_reg       <= 1'b0;
            wv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < ANGLE_STAGES; i++)
            begin
                cv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            mv_reg       <= cv_reg[LAST];
            rv_reg       <= mv_reg;
            wv_reg       <= rv_reg;
            m_tvalid_reg <= wv_reg;
            for (int i = 0; i < ANGLE_STAGES; i++)
            begin
                cv_reg[i] <= cv_in[i];
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            z1_reg    <= z1_next;
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            z2_reg    <= z2_next;
            sqx2_reg  <= sqx2_next;
            sqy2_reg  <= sqy2_next;
            for (int i = 0; i < ANGLE_STAGES; i++)
            begin
                ca_reg[i] <= ca_in[i];
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            ma_reg    <= ca_reg[LAST];
            uh_reg    <= uh_next;
            vh_reg    <= vh_next;
            ul_reg    <= ul_next;
            vl_reg    <= vl_next;
            ra_reg    <= ma_reg;
            ru_reg    <= ru_next;
            rvv_reg   <= vfull[PW-1:RND];
            wa_reg    <= ra_reg;
            wu_reg    <= ru_reg;
            gp_reg    <= gp_next;
            out_a_reg <= wa_reg;
            out_u_reg <= wu_reg;
            out_w_reg <= out_w_next;
        end
    end

endmodule

>>> rtl/ufl_checker.sv
// Port-level checks for the unicycle feedback linearization unit, bound to
// the top level. Depends on ufl_pkg.
module ufl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ufl_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           cfg_ready
);

    // a held output beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // a ready consumer never holds up the input side
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled with consumer ready");

    // a stalled output freezes the pipeline, so no beat may enter
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready && $past(cfg_ready))
        else $error("config port not ready");

endmodule

bind unicycle_feedback_linearization_unit ufl_checker u_ufl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);

>>> tb/tb_unicycle_feedback_linearization_unit.sv
// Self-checking testbench for unicycle_feedback_linearization_unit.
// Directed table then random bursts with random output stalls, checked against
// a behavioural CORDIC predictor. Depends on ufl_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_unicycle_feedback_linearization_unit;

    localparam int    CLK_PERIOD     = 12;
    localparam int    IN_W           = 80;
    localparam int    LATENCY        = ufl_pkg::ANGLE_STAGES_DEFAULT + 6;
    localparam int    RANDOM_POSES   = 950;
    localparam int    TIMEOUT_CYCLES = 500000;
    localparam int    N_DIRECTED     = 27;

    localparam longint QUARTER_TURN = 421657428;
    localparam longint KINV_Q30     = 652032874;
    localparam longint ARCTAN_Q28 [24] = '{
        210828714, 124459457, 65760959, 33381290, 16755421, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] current_x;
        logic signed [15:0] current_y;
        logic signed [15:0] heading;
    } pose_t;

    typedef struct packed {
        logic signed [17:0] linear_drive;
        logic signed [23:0] turn_rate;
        logic               arrived;
    } drive_cmd_t;

    typedef enum logic { ROW_POSE, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        ufl_pkg::cfg_reg_t  addr;
        logic [15:0]        value;
        pose_t              pose;
        logic               typed;
        drive_cmd_t         want;
    } step_t;

    localparam pose_t      NO_POSE = '0;
    localparam drive_cmd_t NO_CMD  = '0;

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [IN_W-1:0]                    s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [ufl_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                               m_tuser;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [ufl_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [ufl_pkg::CFG_DATA_W-1:0]     cfg_data;

    drive_cmd_t  cmd_queue [$];
    logic [15:0] radius_now;
    logic [15:0] gain_now;
    int          mismatches;
    int          cmds_checked;
    int          poses_sent;
    int          reg_writes;
    int          burst_left;

    // Directed stimulus; typed rows carry a result that is obvious by inspection
    step_t directed_steps [N_DIRECTED] = '{
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{18'sd0, 24'sd0, 1'b1}},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sh8000},
          1'b1, '{18'sd0, 24'sd0, 1'b1}},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd32767, 16'sd0, 16'sh8000, 16'sd0, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sh8000, 16'sd0, 16'sd32767, 16'sd0, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd0, 16'sd32767, 16'sd0, 16'sh8000, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd0, 16'sh8000, 16'sd0, 16'sd32767, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd32767, 16'sd32767, 16'sh8000, 16'sh8000, 16'sd25736}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767, -16'sd25736}, 1'b0, NO_CMD},
        // headings past pi need the double quarter-turn
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd256, 16'sd512, 16'sd0, 16'sd0, 16'sd32767}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd256, 16'sd512, 16'sd0, 16'sd0, 16'sh8000}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd12868}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd256, 16'sd0, 16'sd0, 16'sd0, -16'sd12868}, 1'b0, NO_CMD},
        // just inside and exactly on the reset radius
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd25, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd26, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{-16'sd1, -16'sd1, 16'sd0, 16'sd0, -16'sd1}, 1'b0, NO_CMD},
        '{ROW_REG, ufl_pkg::CFG_TURN_GAIN, 16'd0, NO_POSE, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd0, 16'sd32767, 16'sd0, 16'sh8000, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_REG, ufl_pkg::CFG_TURN_GAIN, 16'd65535, NO_POSE, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd0, 16'sd32767, 16'sd0, 16'sh8000, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sh8000, 16'sd32767, 16'sd32767, 16'sh8000, -16'sd25736}, 1'b0, NO_CMD},
        '{ROW_REG, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0, NO_POSE, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{18'sd0, 24'sd0, 1'b0}},
        '{ROW_REG, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd65535, NO_POSE, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd32767, 16'sd0, 16'sh8000, 16'sd0, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_POSE, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0,
          '{16'sd32767, 16'sd0, -16'sd32767, 16'sd0, 16'sd0}, 1'b0, NO_CMD},
        '{ROW_REG, ufl_pkg::CFG_TURN_GAIN, 16'd4096, NO_POSE, 1'b0, NO_CMD},
        '{ROW_REG, ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd26, NO_POSE, 1'b0, NO_CMD}
    };

    unicycle_feedback_linearization_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Rotate the error into the robot frame, scale by 1/K, apply the gain
    function automatic drive_cmd_t steer_command(pose_t p, logic [15:0] radius,
                                                 logic [15:0] gain);
        drive_cmd_t cmd;
        longint     dx, dy, z, x, y, t, xs, ys, u, v, w, dist_sq, radius_sq;
        dx = longint'($signed(p.target_x)) - longint'($signed(p.current_x));
        dy = longint'($signed(p.target_y)) - longint'($signed(p.current_y));
        z  = -(longint'($signed(p.heading)) * 32768);
        x  = dx * 4096;
        y  = dy * 4096;
        for (int k = 0; k < 2; k++)
        begin
            if (z > QUARTER_TURN)
            begin
                t = x; x = -y; y = t; z = z - QUARTER_TURN;
            end
            else if (z < -QUARTER_TURN)
            begin
                t = x; x = y; y = -t; z = z + QUARTER_TURN;
            end
        end
        for (int i = 0; i < ufl_pkg::ANGLE_STAGES_DEFAULT && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - ARCTAN_Q28[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + ARCTAN_Q28[i];
            end
        end
        u = (x * KINV_Q30 + (longint'(1) << 41)) >>> 42;
        v = (y * KINV_Q30 + (longint'(1) << 41)) >>> 42;
        if (u > 131071)
            u = 131071;
        else if (u < -131072)
            u = -131072;
        w = (v * longint'(gain) + 2048) >>> 12;
        if (w > 8388607)
            w = 8388607;
        else if (w < -8388608)
            w = -8388608;
        dist_sq   = dx * dx + dy * dy;
        radius_sq = longint'(radius) * longint'(radius);
        cmd.linear_drive = u[17:0];
        cmd.turn_rate    = w[23:0];
        cmd.arrived      = (dist_sq < radius_sq);
        return cmd;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < 100)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Called at a falling edge; returns at the falling edge after the beat
    task automatic send_pose(pose_t p, logic typed, drive_cmd_t typed_cmd);
        s_tdata  = {p.heading, p.current_y, p.current_x, p.target_y, p.target_x};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        cmd_queue.push_back(typed ? typed_cmd : steer_command(p, radius_now, gain_now));
        poses_sent++;
        @(negedge clk);
    endtask

    // Bursts of random length separated by random gaps, sometimes long runs
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            s_tvalid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (cmd_queue.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(ufl_pkg::cfg_reg_t addr, logic [15:0] value);
        cfg_index = addr;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (addr)
            ufl_pkg::CFG_ARRIVAL_RADIUS: radius_now = value;
            ufl_pkg::CFG_TURN_GAIN:      gain_now   = value;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Output side: ready pattern switches among four modes picked at random
    initial
    begin
        int mode;
        int mode_left;
        int hold;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 3) != 0);
                2: m_tready = ~m_tready;
                default:
                begin
                    if (hold == 0)
                    begin
                        m_tready = ~m_tready;
                        hold = m_tready ? $urandom_range(1, 4) : $urandom_range(1, 30);
                    end
                    else
                    begin
                        hold--;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : beat_check
        drive_cmd_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cmd_queue.size() == 0)
            begin
                report_mismatch("command beat with nothing pending");
            end
            else
            begin
                want = cmd_queue.pop_front();
                if (m_tdata[17:0] !== want.linear_drive)
                    report_mismatch($sformatf("linear_drive got %0d expected %0d",
                        $signed(m_tdata[17:0]), want.linear_drive));
                if (m_tdata[41:18] !== want.turn_rate)
                    report_mismatch($sformatf("turn_rate got %0d expected %0d",
                        $signed(m_tdata[41:18]), want.turn_rate));
                if (m_tuser !== want.arrived)
                    report_mismatch($sformatf("arrived got %b expected %b",
                        m_tuser, want.arrived));
                if (m_tdata[ufl_pkg::OUT_DATA_W-1:42] !== '0)
                    report_mismatch($sformatf("tdata padding not zero: %h",
                        m_tdata[ufl_pkg::OUT_DATA_W-1:42]));
            end
            cmds_checked++;
        end
    end

    initial
    begin
        #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
        $display("timeout with %0d commands outstanding", cmd_queue.size());
        $display("FAIL unicycle_feedback_linearization_unit");
        $finish;
    end

    initial
    begin
        pose_t p;
        int    phase_left;
        int    kind;
        int    cx;
        int    cy;
        int    reach;
        int    random_sent;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = ufl_pkg::CFG_ARRIVAL_RADIUS;
        cfg_data     = '0;
        radius_now   = ufl_pkg::ARRIVAL_RADIUS_RESET;
        gain_now     = ufl_pkg::TURN_GAIN_RESET;
        mismatches   = 0;
        cmds_checked = 0;
        poses_sent   = 0;
        reg_writes   = 0;
        burst_left   = 0;
        random_sent  = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_REG)
            begin
                wait_drained();
                write_register(directed_steps[i].addr, directed_steps[i].value);
            end
            else
            begin
                send_pose(directed_steps[i].pose, directed_steps[i].typed,
                          directed_steps[i].want);
                pace_sender();
            end
        end

        phase_left = $urandom_range(80, 160);
        while (random_sent < RANDOM_POSES)
        begin
            if (phase_left == 0)
            begin
                // idle the block completely before retuning
                wait_drained();
                case ($urandom_range(0, 4))
                    0: write_register(ufl_pkg::CFG_ARRIVAL_RADIUS, 16'd0);
                    1: write_register(ufl_pkg::CFG_ARRIVAL_RADIUS, 16'hFFFF);
                    2: write_register(ufl_pkg::CFG_ARRIVAL_RADIUS,
                                      16'($urandom_range(1, 400)));
                    default: write_register(ufl_pkg::CFG_ARRIVAL_RADIUS, 16'($urandom));
                endcase
                case ($urandom_range(0, 5))
                    0: write_register(ufl_pkg::CFG_TURN_GAIN, 16'd0);
                    1: write_register(ufl_pkg::CFG_TURN_GAIN, 16'd1);
                    2: write_register(ufl_pkg::CFG_TURN_GAIN, 16'hFFFF);
                    3: write_register(ufl_pkg::CFG_TURN_GAIN, ufl_pkg::TURN_GAIN_RESET);
                    default: write_register(ufl_pkg::CFG_TURN_GAIN, 16'($urandom));
                endcase
                phase_left = $urandom_range(80, 160);
            end

            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                // navigation: target a short hop from the robot, heading in range
                cx    = $urandom_range(0, 60000) - 30000;
                cy    = $urandom_range(0, 60000) - 30000;
                reach = (kind < 2) ? 80 : 2048;
                p.current_x = 16'(cx);
                p.current_y = 16'(cy);
                p.target_x  = 16'(cx + $urandom_range(0, 2 * reach) - reach);
                p.target_y  = 16'(cy + $urandom_range(0, 2 * reach) - reach);
                p.heading   = 16'($urandom_range(0, 51472) - 25736);
            end
            else
            begin
                p = pose_t'({$urandom, $urandom, 16'($urandom)});
            end
            send_pose(p, 1'b0, NO_CMD);
            random_sent++;
            phase_left--;
            pace_sender();
        end

        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);

        $display("%0d poses sent, %0d commands checked, %0d register writes",
                 poses_sent, cmds_checked, reg_writes);
        $display("headings covered beyond +-pi, zero gain and zero radius included");
        if (mismatches == 0 && cmd_queue.size() == 0)
        begin
            $display("PASS unicycle_feedback_linearization_unit");
        end
        else
        begin
            $display("%0d mismatches, %0d commands outstanding", mismatches, cmd_queue.size());
            $display("FAIL unicycle_feedback_linearization_unit");
        end
        $finish;
    end

endmodule
